### rtl/core/whc_pkg.sv
// shared types and constants for the write heat classifier
package whc_pkg;

    typedef enum logic [1:0] {
        MODE_RECORD  = 2'd0,
        MODE_RESET   = 2'd1,
        MODE_INHERIT = 2'd2,
        MODE_QUERY   = 2'd3
    } mode_t;

    localparam logic [1:0] REG_INTERVAL    = 2'd0;
    localparam logic [1:0] REG_MIN_SAMPLES = 2'd1;
    localparam logic [1:0] REG_INVALID_ID  = 2'd2;

    localparam int COUNT_BITS = 16;
    localparam int TIME_BITS  = 32;
    localparam int MIN_BITS   = 11;
    localparam int RADIX_BITS = 4;
    localparam int PASSES     = 32;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX        = 16'hFFFF;
    localparam logic [COUNT_BITS-1:0] INTERVAL_DEFAULT = 16'd1024;
    localparam logic [MIN_BITS-1:0]   MIN_DEFAULT      = 11'd16;
    localparam logic [TIME_BITS-1:0]  INVALID_DEFAULT  = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_READ,
        ST_EXEC,
        ST_SCAN,
        ST_DRAIN,
        ST_PASS
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic reduce_step;
        logic read_issue;
        logic exec;
        logic scan_step;
        logic pass_end;
    } cmd_t;

    typedef struct packed {
        logic  clear_last;
        logic  reduce_last;
        mode_t mode;
        logic  trigger;
        logic  out_busy;
        logic  scan_last;
        logic  med_final;
    } sts_t;

endpackage

### rtl/core/write_heat_classifier.sv
// top level of the write heat classifier
//
// input stream: one beat per operation, mode in s_axis_tuser, ids and time in
// s_axis_tdata. modes are record write, reset bucket, inherit and hot query.
// output stream: only a hot query returns a beat, is_hot in m_axis_tdata[0].
// configuration: cfg_we with cfg_addr 0 recompute interval, 1 minimum
// samples, 2 invalid node id; these are to be written only while the block
// is idle, which the user must ensure: the block does not enforce it.
// per operation the bucket index is a remainder formed four bits a cycle,
// then one registered table read and one write or answer. a query answer
// is loaded into the output register from the registered read when the
// query executes; a new beat is taken while that answer waits. when the
// receiver stalls, a following query holds until the output register frees.
// a record write that reaches the interval starts a median search of up to
// 33 passes over the table: the first counts qualifying buckets, each later
// one settles a radix bit of the time column and, within its 16 bits, of the
// count column; it stops after the first pass when none or fewer than the
// minimum number of buckets qualify. no beat is taken meanwhile.
// after reset a clearing sweep zeroes both tables before any beat is taken.
module write_heat_classifier
#(
    parameter int TABLE_DEPTH  = 1024,
    parameter int NODE_ID_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // node_id[31:0], src_node_id[63:32], now_ms[95:64]
    input  logic [1:0]  s_axis_tuser,   // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // is_hot[0], zero fill[7:1]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    whc_pkg::cmd_t cmd;
    whc_pkg::sts_t sts;
    logic          is_hot;

    whc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    whc_datapath
    #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .NODE_ID_BITS (NODE_ID_BITS)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .in_mode        (s_axis_tuser),
        .in_node_id     (s_axis_tdata[31:0]),
        .in_src_node_id (s_axis_tdata[63:32]),
        .in_now_ms      (s_axis_tdata[95:64]),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_is_hot     (is_hot)
    );

    assign m_axis_tdata = {7'b0, is_hot};

endmodule

### rtl/core/whc_ctrl.sv
// controller state machine for the write heat classifier
module whc_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  whc_pkg::sts_t sts,
    output whc_pkg::cmd_t cmd
);

    whc_pkg::state_t state_reg;
    whc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= whc_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            whc_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = whc_pkg::ST_IDLE;
                end
            end
            whc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = whc_pkg::ST_REDUCE;
                end
            end
            whc_pkg::ST_REDUCE:
            begin
                cmd.reduce_step = 1'b1;
                if (sts.reduce_last)
                begin
                    state_next = whc_pkg::ST_READ;
                end
            end
            whc_pkg::ST_READ:
            begin
                cmd.read_issue = 1'b1;
                state_next     = whc_pkg::ST_EXEC;
            end
            whc_pkg::ST_EXEC:
            begin
                // a query waits here while the previous answer is not taken
                if (!(sts.mode == whc_pkg::MODE_QUERY && sts.out_busy))
                begin
                    cmd.exec   = 1'b1;
                    state_next = sts.trigger ? whc_pkg::ST_SCAN : whc_pkg::ST_IDLE;
                end
            end
            whc_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = whc_pkg::ST_DRAIN;
                end
            end
            whc_pkg::ST_DRAIN:
            begin
                state_next = whc_pkg::ST_PASS;
            end
            whc_pkg::ST_PASS:
            begin
                cmd.pass_end = 1'b1;
                state_next   = sts.med_final ? whc_pkg::ST_IDLE : whc_pkg::ST_SCAN;
            end
            default:
            begin
                state_next = whc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/whc_datapath.sv
// tables, bucket reduction, median search and output register
module whc_datapath
#(
    parameter int TABLE_DEPTH  = 1024,
    parameter int NODE_ID_BITS = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  whc_pkg::cmd_t cmd,
    output whc_pkg::sts_t sts,
    input  logic [1:0]    in_mode,
    input  logic [31:0]   in_node_id,
    input  logic [31:0]   in_src_node_id,
    input  logic [31:0]   in_now_ms,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_addr,
    input  logic [31:0]   cfg_wdata,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          out_is_hot
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int ID_W   = (NODE_ID_BITS < 32) ? NODE_ID_BITS : 32;
    localparam int STEPS  = (ID_W + whc_pkg::RADIX_BITS - 1) / whc_pkg::RADIX_BITS;
    localparam int PAD_W  = STEPS * whc_pkg::RADIX_BITS;
    localparam int STEP_W = $clog2(STEPS);
    localparam int CNT_W  = IDX_W + 1;
    localparam int CB     = whc_pkg::COUNT_BITS;
    localparam int TB     = whc_pkg::TIME_BITS;

    localparam logic [IDX_W:0]    DEPTH_V   = (IDX_W + 1)'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0]  LAST_ADDR = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);
    localparam logic [5:0]        LAST_PASS = 6'(whc_pkg::PASSES);
    localparam logic [TB-1:0]     TOP_BIT   = TB'(1) << (TB - 1);

    function automatic logic [IDX_W-1:0] mod_nibble(
        input logic [IDX_W-1:0]               r,
        input logic [whc_pkg::RADIX_BITS-1:0] nib);
        logic [IDX_W:0]   t;
        logic [IDX_W-1:0] acc;
        acc = r;
        for (int i = whc_pkg::RADIX_BITS - 1; i >= 0; i--)
        begin
            t = {acc, nib[i]};
            if (t >= DEPTH_V)
            begin
                t = t - DEPTH_V;
            end
            acc = t[IDX_W-1:0];
        end
        return acc;
    endfunction

    // configuration
    logic [CB-1:0]                interval_reg;
    logic [whc_pkg::MIN_BITS-1:0] min_reg;
    logic [TB-1:0]                inv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= whc_pkg::INTERVAL_DEFAULT;
            min_reg      <= whc_pkg::MIN_DEFAULT;
            inv_reg      <= whc_pkg::INVALID_DEFAULT;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                whc_pkg::REG_INTERVAL:    interval_reg <= cfg_wdata[CB-1:0];
                whc_pkg::REG_MIN_SAMPLES: min_reg      <= cfg_wdata[whc_pkg::MIN_BITS-1:0];
                whc_pkg::REG_INVALID_ID:  inv_reg      <= cfg_wdata;
                default:                  ;
            endcase
        end
    end

    // captured item and bucket reduction
    whc_pkg::mode_t    mode_reg;
    logic [ID_W-1:0]   node_reg;
    logic [ID_W-1:0]   src_reg;
    logic [TB-1:0]     now_reg;
    logic [PAD_W-1:0]  node_sh_reg;
    logic [PAD_W-1:0]  src_sh_reg;
    logic [IDX_W-1:0]  rem_node_reg;
    logic [IDX_W-1:0]  rem_src_reg;
    logic [STEP_W-1:0] step_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg     <= whc_pkg::mode_t'(in_mode);
            node_reg     <= in_node_id[ID_W-1:0];
            src_reg      <= in_src_node_id[ID_W-1:0];
            now_reg      <= in_now_ms;
            node_sh_reg  <= PAD_W'(in_node_id[ID_W-1:0]);
            src_sh_reg   <= PAD_W'(in_src_node_id[ID_W-1:0]);
            rem_node_reg <= '0;
            rem_src_reg  <= '0;
            step_reg     <= '0;
        end
        else if (cmd.reduce_step)
        begin
            rem_node_reg <= mod_nibble(rem_node_reg, node_sh_reg[PAD_W-1 -: whc_pkg::RADIX_BITS]);
            rem_src_reg  <= mod_nibble(rem_src_reg, src_sh_reg[PAD_W-1 -: whc_pkg::RADIX_BITS]);
            node_sh_reg  <= node_sh_reg << whc_pkg::RADIX_BITS;
            src_sh_reg   <= src_sh_reg << whc_pkg::RADIX_BITS;
            step_reg     <= step_reg + STEP_W'(1);
        end
    end

    logic node_inv;
    logic src_inv;
    assign node_inv = (node_reg == inv_reg[ID_W-1:0]);
    assign src_inv  = (src_reg == inv_reg[ID_W-1:0]);

    // tables
    logic [CB-1:0]    cnt_mem  [TABLE_DEPTH];
    logic [TB-1:0]    time_mem [TABLE_DEPTH];
    logic [CB-1:0]    rd_cnt_reg;
    logic [TB-1:0]    rd_time_reg;
    logic [IDX_W-1:0] addr_reg;
    logic             rv_reg;

    logic             exec_wr;
    logic             mem_we;
    logic             mem_re;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] raddr;
    logic [CB-1:0]    wcnt;
    logic [TB-1:0]    wtime;

    always_comb
    begin
        exec_wr = 1'b0;
        wcnt    = '0;
        wtime   = now_reg;
        case (mode_reg)
            whc_pkg::MODE_RECORD:
            begin
                exec_wr = !node_inv;
                wcnt    = (rd_cnt_reg == whc_pkg::COUNT_MAX) ? rd_cnt_reg
                                                             : rd_cnt_reg + CB'(1);
            end
            whc_pkg::MODE_RESET:
            begin
                exec_wr = !node_inv;
            end
            whc_pkg::MODE_INHERIT:
            begin
                exec_wr = !node_inv && !src_inv && (rem_src_reg != rem_node_reg);
                wtime   = rd_time_reg;
            end
            default:
            begin
                exec_wr = 1'b0;
            end
        endcase
    end

    assign mem_we = cmd.clear_step || (cmd.exec && exec_wr);
    assign mem_re = cmd.read_issue || cmd.scan_step;
    assign waddr  = cmd.clear_step ? addr_reg : rem_node_reg;
    assign raddr  = cmd.scan_step ? addr_reg
                  : ((mode_reg == whc_pkg::MODE_INHERIT) ? rem_src_reg : rem_node_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cnt_mem[waddr]  <= cmd.clear_step ? '0 : wcnt;
            time_mem[waddr] <= cmd.clear_step ? '0 : wtime;
        end
        if (mem_re)
        begin
            rd_cnt_reg  <= cnt_mem[raddr];
            rd_time_reg <= time_mem[raddr];
        end
    end

    // write counter
    logic [CB-1:0] wsr_reg;
    logic [CB-1:0] wsr_inc;
    logic          rec_ok;
    logic          trigger;

    assign rec_ok  = (mode_reg == whc_pkg::MODE_RECORD) && !node_inv;
    assign wsr_inc = (wsr_reg == whc_pkg::COUNT_MAX) ? wsr_reg : wsr_reg + CB'(1);
    assign trigger = rec_ok && (wsr_inc >= interval_reg);

    // radix median search, one bit per pass after a tally pass
    logic [5:0]    pass_reg;
    logic [CNT_W-1:0] acc_t_reg;
    logic [CNT_W-1:0] acc_c_reg;
    logic [CNT_W-1:0] k_t_reg;
    logic [CNT_W-1:0] k_c_reg;
    logic [TB-1:0] pt_reg;
    logic [CB-1:0] pc_reg;
    logic [TB-1:0] hi_mask_reg;
    logic [TB-1:0] bitsel_reg;
    logic [CB-1:0] med_cnt_reg;
    logic [TB-1:0] med_time_reg;

    logic          qual;
    logic          c_active;
    logic          match_t;
    logic          match_c;
    logic          zero_cond;
    logic          take_t;
    logic          take_c;
    logic [TB-1:0] pt_new;
    logic [CB-1:0] pc_new;

    assign qual      = rv_reg && (rd_cnt_reg != '0);
    assign c_active  = (bitsel_reg[TB-1:CB] == '0);
    assign match_t   = (((rd_time_reg ^ pt_reg) & hi_mask_reg) == '0)
                    && ((rd_time_reg & bitsel_reg) == '0);
    assign match_c   = c_active && (((rd_cnt_reg ^ pc_reg) & hi_mask_reg[CB-1:0]) == '0)
                    && ((rd_cnt_reg & bitsel_reg[CB-1:0]) == '0);
    assign zero_cond = (acc_t_reg == '0) || (32'(acc_t_reg) < 32'(min_reg));
    assign take_t    = (k_t_reg >= acc_t_reg);
    assign take_c    = c_active && (k_c_reg >= acc_c_reg);
    assign pt_new    = take_t ? (pt_reg | bitsel_reg) : pt_reg;
    assign pc_new    = take_c ? (pc_reg | bitsel_reg[CB-1:0]) : pc_reg;

    logic out_valid_reg;
    logic is_hot_reg;
    logic hot;

    always_comb
    begin
        if (node_inv)
        begin
            hot = 1'b0;
        end
        else if (med_cnt_reg == '0 && med_time_reg == '0)
        begin
            hot = 1'b1;
        end
        else
        begin
            hot = (rd_cnt_reg > med_cnt_reg) || (rd_time_reg > med_time_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= '0;
            rv_reg        <= 1'b0;
            wsr_reg       <= '0;
            pass_reg      <= '0;
            acc_t_reg     <= '0;
            acc_c_reg     <= '0;
            med_cnt_reg   <= '0;
            med_time_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rv_reg <= cmd.scan_step;
            if (cmd.clear_step || cmd.scan_step)
            begin
                addr_reg <= (addr_reg == LAST_ADDR) ? '0 : addr_reg + IDX_W'(1);
            end
            else if (cmd.pass_end || (cmd.exec && trigger))
            begin
                addr_reg <= '0;
            end

            if (cmd.exec && rec_ok)
            begin
                wsr_reg <= trigger ? '0 : wsr_inc;
            end

            if (cmd.exec && trigger)
            begin
                pass_reg  <= '0;
                acc_t_reg <= '0;
                acc_c_reg <= '0;
            end
            else if (cmd.pass_end)
            begin
                pass_reg  <= pass_reg + 6'd1;
                acc_t_reg <= '0;
                acc_c_reg <= '0;
                if (pass_reg == '0)
                begin
                    if (zero_cond)
                    begin
                        med_cnt_reg  <= '0;
                        med_time_reg <= '0;
                    end
                end
                else if (pass_reg == LAST_PASS)
                begin
                    med_cnt_reg  <= pc_new;
                    med_time_reg <= pt_new;
                end
            end
            else
            begin
                if (qual && (pass_reg == '0 || match_t))
                begin
                    acc_t_reg <= acc_t_reg + CNT_W'(1);
                end
                if (qual && pass_reg != '0 && match_c)
                begin
                    acc_c_reg <= acc_c_reg + CNT_W'(1);
                end
            end

            if (cmd.exec && mode_reg == whc_pkg::MODE_QUERY)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && mode_reg == whc_pkg::MODE_QUERY)
        begin
            is_hot_reg <= hot;
        end
        if (cmd.pass_end)
        begin
            if (pass_reg == '0)
            begin
                k_t_reg     <= acc_t_reg >> 1;
                k_c_reg     <= acc_t_reg >> 1;
                pt_reg      <= '0;
                pc_reg      <= '0;
                hi_mask_reg <= '0;
                bitsel_reg  <= TOP_BIT;
            end
            else
            begin
                pt_reg      <= pt_new;
                pc_reg      <= pc_new;
                k_t_reg     <= take_t ? k_t_reg - acc_t_reg : k_t_reg;
                k_c_reg     <= take_c ? k_c_reg - acc_c_reg : k_c_reg;
                hi_mask_reg <= hi_mask_reg | bitsel_reg;
                bitsel_reg  <= bitsel_reg >> 1;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_is_hot = is_hot_reg;

    always_comb
    begin
        sts.clear_last  = (addr_reg == LAST_ADDR);
        sts.reduce_last = (step_reg == LAST_STEP);
        sts.mode        = mode_reg;
        sts.trigger     = trigger;
        sts.out_busy    = out_valid_reg && !out_ready;
        sts.scan_last   = (addr_reg == LAST_ADDR);
        sts.med_final   = ((pass_reg == '0) && zero_cond) || (pass_reg == LAST_PASS);
    end

    a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(acc_t_reg) <= 32'(TABLE_DEPTH)) && (32'(acc_c_reg) <= 32'(TABLE_DEPTH)))
        else $error("median tally exceeds table depth");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read_issue |-> (32'(rem_node_reg) < 32'(TABLE_DEPTH))
                        && (32'(rem_src_reg) < 32'(TABLE_DEPTH)))
        else $error("bucket index out of range");

    a_query_out: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && mode_reg == whc_pkg::MODE_QUERY) |=> out_valid_reg)
        else $error("query answer not presented");

    a_no_write_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> !mem_we)
        else $error("table written during median scan");

endmodule

### sim/tb_write_heat_classifier.sv
// testbench for the write heat classifier: directed and random operations vs a predictor
module tb_write_heat_classifier;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 1024;
    localparam int STALL_LIMIT = 150000;

    // predictor of bucket heat plus the queue of expected query answers
    class heat_scoreboard;
        logic [15:0] cnt_tab [DEPTH];
        logic [31:0] time_tab [DEPTH];
        logic [15:0] med_cnt;
        logic [31:0] med_time;
        logic [15:0] writes_seen;
        logic [15:0] interval;
        logic [10:0] min_need;
        logic [31:0] bad_id;
        bit answers [$];
        int errors;
        int queries;
        int recomputes;

        function new();
            foreach (cnt_tab[i])
            begin
                cnt_tab[i] = '0;
                time_tab[i] = '0;
            end
            med_cnt = '0;
            med_time = '0;
            writes_seen = '0;
            interval = whc_pkg::INTERVAL_DEFAULT;
            min_need = whc_pkg::MIN_DEFAULT;
            bad_id = whc_pkg::INVALID_DEFAULT;
            errors = 0;
            queries = 0;
            recomputes = 0;
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        function void set_reg(logic [1:0] addr, logic [31:0] val);
            case (addr)
                whc_pkg::REG_INTERVAL:    interval = val[15:0];
                whc_pkg::REG_MIN_SAMPLES: min_need = val[10:0];
                whc_pkg::REG_INVALID_ID:  bad_id = val;
                default: ;
            endcase
        endfunction

        function void recompute();
            logic [15:0] cq [$];
            logic [31:0] tq [$];
            int n;
            for (int i = 0; i < DEPTH; i++)
                if (cnt_tab[i] != 0)
                begin
                    cq.push_back(cnt_tab[i]);
                    tq.push_back(time_tab[i]);
                end
            cq.sort();
            tq.sort();
            n = cq.size();
            recomputes++;
            if (n == 0 || n < min_need)
            begin
                med_cnt = '0;
                med_time = '0;
            end
            else
            begin
                med_cnt = cq[n/2];
                med_time = tq[n/2];
            end
        endfunction

        function void note(whc_pkg::mode_t mode, logic [31:0] node, logic [31:0] src,
                           logic [31:0] now);
            int b;
            int sb;
            b = node % DEPTH;
            sb = src % DEPTH;
            case (mode)
                whc_pkg::MODE_RECORD:
                    if (node != bad_id)
                    begin
                        if (cnt_tab[b] != whc_pkg::COUNT_MAX)
                            cnt_tab[b]++;
                        time_tab[b] = now;
                        if (writes_seen != whc_pkg::COUNT_MAX)
                            writes_seen++;
                        if (writes_seen >= interval)
                        begin
                            writes_seen = '0;
                            recompute();
                        end
                    end
                whc_pkg::MODE_RESET:
                    if (node != bad_id)
                    begin
                        cnt_tab[b] = '0;
                        time_tab[b] = now;
                    end
                whc_pkg::MODE_INHERIT:
                    if (node != bad_id && src != bad_id && sb != b)
                    begin
                        cnt_tab[b] = '0;
                        time_tab[b] = time_tab[sb];
                    end
                default:
                begin
                    queries++;
                    if (node == bad_id)
                        answers.push_back(1'b0);
                    else if (med_cnt == 0 && med_time == 0)
                        answers.push_back(1'b1);
                    else
                        answers.push_back(cnt_tab[b] > med_cnt || time_tab[b] > med_time);
                end
            endcase
        endfunction

        task check(logic hot);
            bit want;
            if (answers.size() == 0)
                report($sformatf("unexpected answer beat is_hot=%0b", hot));
            else
            begin
                want = answers.pop_front();
                if (hot !== want)
                    report($sformatf("is_hot got %0b want %0b", hot, want));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [31:0] cfg_wdata;

    heat_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off;
    int quiet_cycles;
    int beats_in;

    write_heat_classifier u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // both sides sampled at the rising edge; answers checked before new beats are noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check(m_axis_tdata[0]);
            if (s_axis_tvalid && s_axis_tready)
            begin
                sb.note(whc_pkg::mode_t'(s_axis_tuser), s_axis_tdata[31:0],
                        s_axis_tdata[63:32], s_axis_tdata[95:64]);
                beats_in++;
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles", STALL_LIMIT);
                $display("** write_heat_classifier: FAILED **");
                $finish;
            end
        end
    end

    // receiver: long hold-off when asked, otherwise random stalls
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            m_axis_tready = 1'b0;
            hold_off--;
        end
        else
            m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    task send(whc_pkg::mode_t mode, logic [31:0] node, logic [31:0] src, logic [31:0] now);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = mode;
        s_axis_tdata = {now, src, node};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // waits for all answers, then for the input side to stay open long enough to rule out a
    // pending operation or median search
    task settle();
        int open_run;
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (sb.answers.size() != 0)
            @(posedge clk);
        open_run = 0;
        while (open_run < 32)
        begin
            @(posedge clk);
            open_run = s_axis_tready ? open_run + 1 : 0;
        end
    endtask

    task write_reg(logic [1:0] addr, logic [31:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_addr = addr;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.set_reg(addr, val);
    endtask

    function logic [31:0] pick_node();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return sb.bad_id;
        else if (r < 80)
            return {22'($urandom() >> 10), 10'($urandom_range(23))};
        else
            return $urandom();
    endfunction

    task random_ops(int n);
        int r;
        logic [31:0] node;
        logic [31:0] src;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            node = pick_node();
            src = ($urandom_range(9) == 0) ? node : pick_node();
            if (r < 40)
                send(whc_pkg::MODE_RECORD, node, src, $urandom());
            else if (r < 50)
                send(whc_pkg::MODE_RESET, node, src, $urandom());
            else if (r < 65)
                send(whc_pkg::MODE_INHERIT, node, src, $urandom());
            else
                send(whc_pkg::MODE_QUERY, node, src, $urandom());
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = whc_pkg::MODE_RECORD;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = whc_pkg::REG_INTERVAL;
        cfg_wdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 0;
        quiet_cycles = 0;
        beats_in = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // defaults: medians zero so every valid query is hot
        send(whc_pkg::MODE_QUERY, 32'd5, 32'd0, 32'd0);
        send(whc_pkg::MODE_QUERY, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send(whc_pkg::MODE_RECORD, 32'd0, 32'd0, 32'd0);
        send(whc_pkg::MODE_RECORD, 32'hFFFF_FFFF, 32'd0, 32'd7);
        send(whc_pkg::MODE_RECORD, 32'h0000_03FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(whc_pkg::MODE_RESET, 32'd5, 32'd0, 32'h1234_5678);
        send(whc_pkg::MODE_RESET, 32'hFFFF_FFFF, 32'd0, 32'd1);
        send(whc_pkg::MODE_INHERIT, 32'd7, 32'h0000_03FF, 32'd0);
        send(whc_pkg::MODE_INHERIT, 32'h0000_0400, 32'd0, 32'd0);
        send(whc_pkg::MODE_INHERIT, 32'd9, 32'hFFFF_FFFF, 32'd0);
        send(whc_pkg::MODE_INHERIT, 32'hFFFF_FFFF, 32'd5, 32'd0);
        send(whc_pkg::MODE_QUERY, 32'h0000_03FF, 32'd0, 32'd0);
        settle();

        // recompute after every write, one sample enough, zero is the invalid id
        write_reg(whc_pkg::REG_INTERVAL, 32'd1);
        write_reg(whc_pkg::REG_MIN_SAMPLES, 32'd1);
        write_reg(whc_pkg::REG_INVALID_ID, 32'd0);
        send(whc_pkg::MODE_RECORD, 32'd1, 32'd0, 32'd100);
        send(whc_pkg::MODE_QUERY, 32'd1, 32'd0, 32'd0);
        send(whc_pkg::MODE_QUERY, 32'd2, 32'd0, 32'd0);
        send(whc_pkg::MODE_RECORD, 32'd0, 32'd0, 32'd999);
        send(whc_pkg::MODE_QUERY, 32'd0, 32'd0, 32'd0);
        send(whc_pkg::MODE_RECORD, 32'd2, 32'd0, 32'd50);
        send(whc_pkg::MODE_QUERY, 32'd1, 32'd0, 32'd0);
        send(whc_pkg::MODE_QUERY, 32'd2, 32'd0, 32'd0);
        settle();

        // interval zero and min samples zero, then an unreachable sample count
        write_reg(whc_pkg::REG_INTERVAL, 32'd0);
        write_reg(whc_pkg::REG_MIN_SAMPLES, 32'd0);
        send(whc_pkg::MODE_RECORD, 32'd3, 32'd0, 32'd10);
        send(whc_pkg::MODE_QUERY, 32'd3, 32'd0, 32'd0);
        send(whc_pkg::MODE_QUERY, 32'd1, 32'd0, 32'd0);
        settle();
        write_reg(whc_pkg::REG_MIN_SAMPLES, 32'd1024);
        send(whc_pkg::MODE_RECORD, 32'd4, 32'd0, 32'd10);
        send(whc_pkg::MODE_QUERY, 32'd4, 32'd0, 32'd0);
        settle();

        // random phases: no idling, sender idle, receiver stalls, both
        write_reg(whc_pkg::REG_INTERVAL, 32'd30);
        write_reg(whc_pkg::REG_MIN_SAMPLES, 32'd3);
        write_reg(whc_pkg::REG_INVALID_ID, $urandom());
        random_ops(100);
        settle();

        // interval far above the writes sent; long receiver hold-off fills the block
        write_reg(whc_pkg::REG_INTERVAL, 32'd65535);
        write_reg(whc_pkg::REG_MIN_SAMPLES, 32'd1);
        write_reg(whc_pkg::REG_INVALID_ID, 32'hFFFF_FFFF);
        send_idle_pct = 64;
        hold_off = 400;
        random_ops(100);
        settle();

        // lowered interval triggers on the next write
        write_reg(whc_pkg::REG_INTERVAL, 32'd20);
        write_reg(whc_pkg::REG_MIN_SAMPLES, 32'd8);
        send_idle_pct = 0;
        recv_stall_pct = 64;
        random_ops(100);
        settle();

        write_reg(whc_pkg::REG_INTERVAL, 32'd50);
        write_reg(whc_pkg::REG_MIN_SAMPLES, 32'd2);
        write_reg(whc_pkg::REG_INVALID_ID, 32'd3);
        send_idle_pct = 36;
        recv_stall_pct = 36;
        random_ops(100);
        settle();
        repeat (40) @(posedge clk);

        $display("covered %0d operations, %0d hot queries, %0d median searches",
                 beats_in, sb.queries, sb.recomputes);
        $display("phases ran with no idling, sender gaps, receiver stalls and both");
        if (sb.errors == 0 && sb.answers.size() == 0)
            $display("** write_heat_classifier: PASSED **");
        else
            $display("** write_heat_classifier: FAILED **");
        $finish;
    end
endmodule

### files.f
rtl/core/whc_pkg.sv
rtl/core/whc_ctrl.sv
rtl/core/whc_datapath.sv
rtl/core/write_heat_classifier.sv
sim/tb_write_heat_classifier.sv
